FILE: rtl/tdre_pkg.sv
// Shared types, codes and the backoff table of the TFTP data receive engine.
package tdre_pkg;

    localparam logic [1:0] FUNC_REQUEST = 2'd0;
    localparam logic [1:0] FUNC_PACKET  = 2'd1;
    localparam logic [1:0] FUNC_TICK    = 2'd2;
    localparam logic [1:0] FUNC_BEGIN   = 2'd3;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_FAIL   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] CFG_BLOCK_SIZE     = 2'd0;
    localparam logic [1:0] CFG_START_BLOCK    = 2'd1;
    localparam logic [1:0] CFG_START_POSITION = 2'd2;

    localparam logic [15:0] OPCODE_DATA  = 16'd3;
    localparam logic [15:0] HEADER_BYTES = 16'd4;
    localparam logic [12:0] MIN_BLOCK    = 13'd64;
    localparam logic [12:0] BLOCK_SIZE_RESET = 13'd512;
    localparam logic [7:0]  ELAPSED_MAX  = 8'd255;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] packet_opcode;
        logic [15:0] packet_serial;
        logic [15:0] packet_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] ack_number;
        logic [12:0] payload_bytes;
        logic [31:0] file_position;
        logic        end_of_file;
        logic        last;
    } t_out_item;

    // One classified event: one or two results ready to send.
    typedef struct packed {
        logic      two;
        t_out_item first;
        t_out_item second;
    } t_cmd;

    function automatic logic [7:0] backoff_limit(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:  v = 8'd2;
            5'd1:  v = 8'd2;
            5'd2:  v = 8'd3;
            5'd3:  v = 8'd3;
            5'd4:  v = 8'd4;
            5'd5:  v = 8'd5;
            5'd6:  v = 8'd6;
            5'd7:  v = 8'd7;
            5'd8:  v = 8'd9;
            5'd9:  v = 8'd10;
            5'd10: v = 8'd12;
            5'd11: v = 8'd15;
            5'd12: v = 8'd18;
            5'd13: v = 8'd21;
            5'd14: v = 8'd26;
            5'd15: v = 8'd31;
            5'd16: v = 8'd37;
            5'd17: v = 8'd44;
            5'd18: v = 8'd53;
            5'd19: v = 8'd64;
            5'd20: v = 8'd77;
            5'd21: v = 8'd92;
            5'd22: v = 8'd110;
            5'd23: v = 8'd132;
            5'd24: v = 8'd159;
            5'd25: v = 8'd191;
            5'd26: v = 8'd229;
            5'd27: v = 8'd255;
            5'd28: v = 8'd255;
            5'd29: v = 8'd255;
            5'd30: v = 8'd255;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/tdre_front.sv
// Front end: configuration registers, transfer state and event classification.
module tdre_front
    import tdre_pkg::*;
#(
    parameter int MAX_BLOCK_SIZE = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_accept,
    input  t_in_item    i_item,
    output logic        o_cmd_push,
    output t_cmd        o_cmd
);

    localparam logic [16:0] MaxBlk = 17'(MAX_BLOCK_SIZE);

    logic [12:0] r_block_size;
    logic [15:0] r_start_block;
    logic [31:0] r_start_pos;

    logic [15:0] r_last_block, n_last_block;
    logic [31:0] r_position, n_position;
    logic        r_waiting, n_waiting;
    logic        r_finished, n_finished;
    logic [4:0]  r_backoff_idx, n_backoff_idx;
    logic [7:0]  r_elapsed, n_elapsed;

    logic [16:0] eff_bs;
    logic [17:0] len_limit;
    logic [15:0] len_cut;
    logic [15:0] payload;
    logic [31:0] new_pos;
    logic        eof;
    logic [7:0]  tick_count;
    logic [4:0]  next_idx;
    logic        pkt_ok;
    t_out_item   res_none;
    t_out_item   res_ack_last;
    t_cmd        cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BLOCK_SIZE_RESET;
            r_start_block <= '0;
            r_start_pos <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_BLOCK_SIZE:     r_block_size <= i_cfg_data[12:0];
                CFG_START_BLOCK:    r_start_block <= i_cfg_data[15:0];
                CFG_START_POSITION: r_start_pos <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        // clamp the block size to the supported range
        if (r_block_size < MIN_BLOCK) begin
            eff_bs = {4'd0, MIN_BLOCK};
        end else if ({4'd0, r_block_size} > MaxBlk) begin
            eff_bs = MaxBlk;
        end else begin
            eff_bs = {4'd0, r_block_size};
        end
        len_limit = {1'b0, eff_bs} + 18'(HEADER_BYTES);
        if ({2'd0, i_item.packet_length} > len_limit) begin
            len_cut = len_limit[15:0];
        end else begin
            len_cut = i_item.packet_length;
        end
        payload = len_cut - HEADER_BYTES;
        new_pos = r_position + {16'd0, payload};
        eof = {1'b0, payload} < eff_bs;
        tick_count = (r_elapsed < ELAPSED_MAX) ? r_elapsed + 8'd1 : ELAPSED_MAX;
        next_idx = r_backoff_idx + 5'd1;
        pkt_ok = r_waiting && (i_item.packet_length >= HEADER_BYTES)
                 && (i_item.packet_opcode == OPCODE_DATA);
    end

    always_comb begin
        res_none = '{kind: KIND_NONE, ack_number: 16'd0, payload_bytes: 13'd0,
                     file_position: 32'd0, end_of_file: 1'b0, last: 1'b1};
        res_ack_last = res_none;
        res_ack_last.kind = KIND_ACK;
        res_ack_last.ack_number = r_last_block;

        n_last_block = r_last_block;
        n_position = r_position;
        n_waiting = r_waiting;
        n_finished = r_finished;
        n_backoff_idx = r_backoff_idx;
        n_elapsed = r_elapsed;
        cmd.two = 1'b0;
        cmd.first = res_none;
        cmd.second = res_none;

        case (i_item.func)
            FUNC_BEGIN: begin
                n_last_block = r_start_block;
                n_position = r_start_pos;
                n_waiting = 1'b0;
                n_finished = 1'b0;
                n_backoff_idx = '0;
                n_elapsed = '0;
            end
            FUNC_REQUEST: begin
                if (!r_finished) begin
                    n_waiting = 1'b1;
                    n_backoff_idx = '0;
                    n_elapsed = '0;
                    cmd.first = res_ack_last;
                end
            end
            FUNC_TICK: begin
                if (r_waiting) begin
                    n_elapsed = tick_count;
                    if (tick_count >= backoff_limit(r_backoff_idx)) begin
                        n_elapsed = '0;
                        n_backoff_idx = next_idx;
                        if (backoff_limit(next_idx) == 8'd0) begin
                            n_waiting = 1'b0;
                            cmd.first.kind = KIND_FAIL;
                        end else begin
                            cmd.first = res_ack_last;
                        end
                    end
                end
            end
            default: begin
                if (pkt_ok) begin
                    if (i_item.packet_serial != r_last_block + 16'd1) begin
                        cmd.first = res_ack_last;
                    end else begin
                        n_last_block = i_item.packet_serial;
                        n_position = new_pos;
                        n_waiting = 1'b0;
                        cmd.second.kind = KIND_ACCEPT;
                        cmd.second.payload_bytes = payload[12:0];
                        cmd.second.file_position = new_pos;
                        cmd.second.end_of_file = eof;
                        if (eof) begin
                            // short block: ACK it first, then report it
                            n_finished = 1'b1;
                            cmd.two = 1'b1;
                            cmd.first.kind = KIND_ACK;
                            cmd.first.ack_number = i_item.packet_serial;
                            cmd.first.last = 1'b0;
                        end else begin
                            cmd.first = cmd.second;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_block <= '0;
            r_position <= '0;
            r_waiting <= 1'b0;
            r_finished <= 1'b0;
            r_backoff_idx <= '0;
            r_elapsed <= '0;
        end else if (i_accept) begin
            r_last_block <= n_last_block;
            r_position <= n_position;
            r_waiting <= n_waiting;
            r_finished <= n_finished;
            r_backoff_idx <= n_backoff_idx;
            r_elapsed <= n_elapsed;
        end
    end

    assign o_cmd_push = i_accept;
    assign o_cmd = cmd;

endmodule

FILE: rtl/tdre_queue.sv
// Short command queue between the front end and the back end.
module tdre_queue
    import tdre_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full = (r_count == FullCnt);
    assign o_valid = (r_count != '0);
    assign o_data = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/tdre_back.sv
// Back end: expands queued commands into result transactions through an output register.
module tdre_back
    import tdre_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_pop
);

    logic      r_valid;
    t_out_item r_item;
    logic      r_second;
    logic      load;

    assign load = !r_valid || i_pop;
    assign o_cmd_pop = load && i_cmd_valid && (r_second || !i_cmd.two);
    assign o_valid = r_valid;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (load && i_cmd_valid) begin
            r_item <= r_second ? i_cmd.second : i_cmd.first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid <= i_cmd_valid;
            if (i_cmd_valid) begin
                // hold the command at the queue head until its second result goes out
                r_second <= !r_second && i_cmd.two;
            end
        end
    end

endmodule

FILE: rtl/tftp_data_receive_engine_unit.sv
// Top level of the TFTP data receive engine.
//
// Input channel: push/full. An event transaction (request, packet, tick, begin)
// is taken at a clock edge with push high and full low; one event per cycle.
// Result channel: empty/pop. The oldest result sits on o_out_item while empty is
// low and leaves at an edge with pop high. Each event gives one or two results;
// the final one carries last.
// Configuration: cfg_wr_en, cfg_idx, cfg_data; write only while the engine is idle.
// An event's command is written into the queue and then loaded into the output
// register, which drives the ports. Throughput: one event per cycle into the front
// end while full is low, one result per cycle out of the back end while pop is
// high, set by the single output register; a short-block event holds it for both its results.
// A command queue of QUEUE_DEPTH entries sits between the two; full rises when
// it fills, so a stalled receiver backs up into the input after QUEUE_DEPTH + 1
// events (QUEUE_DEPTH when a short-block event heads the queue).
// Reset (synchronous, active low) empties the queue and output register, loads the
// default block size of 512 and clears the transfer state.
module tftp_data_receive_engine_unit
    import tdre_pkg::*;
#(
    parameter int MAX_BLOCK_SIZE = 4096,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out_item
);

    logic accept;
    logic cmd_push;
    t_cmd cmd_in;
    logic cmd_valid;
    t_cmd cmd_head;
    logic cmd_pop;
    logic out_valid;

    assign accept = push && !full;
    assign empty = !out_valid;

    tdre_front #(
        .MAX_BLOCK_SIZE(MAX_BLOCK_SIZE)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_accept(accept),
        .i_item(i_in_item),
        .o_cmd_push(cmd_push),
        .o_cmd(cmd_in)
    );

    tdre_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(cmd_push),
        .i_data(cmd_in),
        .o_full(full),
        .i_pop(cmd_pop),
        .o_valid(cmd_valid),
        .o_data(cmd_head)
    );

    tdre_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd(cmd_head),
        .o_cmd_pop(cmd_pop),
        .o_valid(out_valid),
        .o_item(o_out_item),
        .i_pop(pop)
    );

    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.kind == KIND_NONE) |-> o_out_item.last)
        else $error("none result without last");

    a_accept_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.kind == KIND_ACCEPT) |-> o_out_item.last)
        else $error("accepted block not final result");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.kind == KIND_FAIL)
            |-> (o_out_item.last && o_out_item.ack_number == 16'd0))
        else $error("bad failure result");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (empty && !cmd_valid))
        else $error("results present after reset");

endmodule
